// File: hdl/swma_pkg.sv
// Shared widths and parameter defaults for the sliding-window median alert.
`default_nettype none
package swma_pkg;

   localparam int SAMPLE_W       = 8;
   localparam int CFG_W          = 11;
   localparam int MEDIAN_W       = 9;
   localparam int TOTAL_W        = 32;
   localparam int VALUE_MAX_DEF  = 200;
   localparam int WINDOW_MAX_DEF = 1024;

endpackage
`default_nettype wire

// File: hdl/swma_if.sv
// Valid/ready channel interfaces for sample requests and alert responses.
`default_nettype none
interface swma_req_if
   import swma_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface swma_rsp_if
   import swma_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                window_full;
   logic [MEDIAN_W-1:0] median_doubled;
   logic                notify;
   logic [TOTAL_W-1:0]  notify_total;

   modport source (output valid, output window_full, output median_doubled,
                   output notify, output notify_total, input ready);
   modport sink   (input valid, input window_full, input median_doubled,
                   input notify, input notify_total, output ready);
endinterface
`default_nettype wire

// File: hdl/swma_hist_mem.sv
// Histogram memory: one port, registered read, per-bin valid bits for clearing.
`default_nettype none
module swma_hist_mem
   import swma_pkg::*;
#(
   parameter int VALUE_MAX  = VALUE_MAX_DEF,
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  clear,
   input  wire logic                                  wr_en,
   input  wire logic [$clog2(VALUE_MAX+1)-1:0]        addr,
   input  wire logic [$clog2(WINDOW_MAX+1)-1:0]       wr_data,
   output      logic [$clog2(WINDOW_MAX+1)-1:0]       rd_data
);

   localparam int DEPTH = VALUE_MAX + 1;
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);

   logic [CNT_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [CNT_W-1:0] rd_raw_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_raw_ff   <= mem_ff[addr];
      rd_valid_ff <= valid_ff[addr];
   end

   // a bin never written since the last clear reads as zero
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule
`default_nettype wire

// File: hdl/swma_ring_mem.sv
// Sample delay line: single-port ring memory with registered read.
`default_nettype none
module swma_ring_mem
   import swma_pkg::*;
#(
   parameter int VALUE_MAX  = VALUE_MAX_DEF,
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  wire logic                                                   clock,
   input  wire logic                                                   wr_en,
   input  wire logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] addr,
   input  wire logic [$clog2(VALUE_MAX+1)-1:0]                         wr_data,
   output      logic [$clog2(VALUE_MAX+1)-1:0]                         rd_data
);

   localparam int VAL_W = $clog2(VALUE_MAX + 1);

   logic [VAL_W-1:0] mem_ff [WINDOW_MAX];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end

endmodule
`default_nettype wire

// File: hdl/swma_ctrl.sv
// Sequencer: window control, histogram median scan, update and result register.
`default_nettype none
module swma_ctrl
   import swma_pkg::*;
#(
   parameter int VALUE_MAX  = VALUE_MAX_DEF,
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  wire logic                                                   clock,
   input  wire logic                                                   reset,
   swma_req_if.sink                                                    req_ch,
   swma_rsp_if.source                                                  rsp_ch,
   input  wire logic                                                   csr_wr_en,
   input  wire logic [CFG_W-1:0]                                       csr_wr_data,
   output      logic                                                   hist_clear,
   output      logic                                                   hist_wr_en,
   output      logic [$clog2(VALUE_MAX+1)-1:0]                         hist_addr,
   output      logic [$clog2(WINDOW_MAX+1)-1:0]                        hist_wr_data,
   input  wire logic [$clog2(WINDOW_MAX+1)-1:0]                        hist_rd_data,
   output      logic                                                   ring_wr_en,
   output      logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] ring_addr,
   output      logic [$clog2(VALUE_MAX+1)-1:0]                         ring_wr_data,
   input  wire logic [$clog2(VALUE_MAX+1)-1:0]                         ring_rd_data
);

   localparam int VAL_W = $clog2(VALUE_MAX + 1);
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int RA_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int MD_W  = VAL_W + 1;
   localparam int PW    = CNT_W + 1;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SCAN     = 4'd1;
   localparam logic [3:0] ST_SCAN_END = 4'd2;
   localparam logic [3:0] ST_OLD_RD   = 4'd3;
   localparam logic [3:0] ST_OLD_WAIT = 4'd4;
   localparam logic [3:0] ST_DEC      = 4'd5;
   localparam logic [3:0] ST_INC_RD   = 4'd6;
   localparam logic [3:0] ST_INC_WR   = 4'd7;
   localparam logic [3:0] ST_DONE     = 4'd8;

   typedef struct packed {
      logic                window_full;
      logic [MEDIAN_W-1:0] median_doubled;
      logic                notify;
      logic [TOTAL_W-1:0]  notify_total;
   } rsp_type;

   logic [3:0]         state_ff, state_in;
   logic [CNT_W-1:0]   len_ff, len_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [RA_W-1:0]    wp_ff, wp_in;
   logic [TOTAL_W-1:0] alert_ff, alert_in;
   logic [VAL_W-1:0]   s_ff, s_in;
   logic               full_ff, full_in;
   logic [VAL_W-1:0]   old_ff, old_in;
   logic               note_ff, note_in;
   logic [VAL_W-1:0]   scan_addr_ff, scan_addr_in;
   logic               scan_vld_ff, scan_vld_in;
   logic [VAL_W-1:0]   scan_v_ff, scan_v_in;
   logic [CNT_W-1:0]   acc_ff, acc_in;
   logic               eq_ff, eq_in;
   logic [VAL_W-1:0]   lo_ff, lo_in;
   logic               found_ff, found_in;
   logic [MD_W-1:0]    md_ff, md_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               req_fire;
   logic               rsp_free;
   logic [CNT_W-1:0]   acc_sum;
   logic [CNT_W-1:0]   half;
   logic [CNT_W-1:0]   need;
   logic [PW-1:0]      wp_ext;
   logic [PW-1:0]      len_ext;
   logic [RA_W-1:0]    old_pos;
   logic [VAL_W-1:0]   s_sat;
   logic [CNT_W-1:0]   len_eff;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   assign s_sat = (32'(req_ch.sample) > VALUE_MAX) ? VAL_W'(VALUE_MAX)
                                                    : VAL_W'(req_ch.sample);

   always_comb begin
      if (csr_wr_data == '0) begin
         len_eff = CNT_W'(1);
      end else if (32'(csr_wr_data) > WINDOW_MAX) begin
         len_eff = CNT_W'(WINDOW_MAX);
      end else begin
         len_eff = CNT_W'(csr_wr_data);
      end
   end

   // oldest entry sits len places behind the write pointer, modulo ring size
   assign wp_ext  = PW'(wp_ff);
   assign len_ext = PW'(len_ff);
   assign old_pos = (wp_ext >= len_ext) ? RA_W'(wp_ext - len_ext)
                                        : RA_W'(wp_ext + PW'(WINDOW_MAX) - len_ext);

   assign acc_sum = acc_ff + hist_rd_data;
   assign half    = len_ff >> 1;
   assign need    = half + CNT_W'(1);

   always_comb begin
      hist_clear   = csr_wr_en;
      hist_wr_en   = 1'b0;
      hist_addr    = s_ff;
      hist_wr_data = hist_rd_data + CNT_W'(1);
      ring_wr_en   = 1'b0;
      ring_addr    = old_pos;
      ring_wr_data = s_ff;
      case (state_ff)
         ST_SCAN: begin
            hist_addr = scan_addr_ff;
         end
         ST_OLD_WAIT: begin
            hist_addr = ring_rd_data;
         end
         ST_DEC: begin
            hist_addr    = old_ff;
            hist_wr_en   = 1'b1;
            hist_wr_data = (hist_rd_data != '0) ? hist_rd_data - CNT_W'(1) : '0;
         end
         ST_INC_WR: begin
            hist_wr_en = 1'b1;
            ring_wr_en = 1'b1;
            ring_addr  = wp_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      fill_in      = fill_ff;
      wp_in        = wp_ff;
      alert_in     = alert_ff;
      s_in         = s_ff;
      full_in      = full_ff;
      old_in       = old_ff;
      note_in      = note_ff;
      scan_addr_in = scan_addr_ff;
      scan_vld_in  = 1'b0;
      scan_v_in    = scan_v_ff;
      acc_in       = acc_ff;
      eq_in        = eq_ff;
      lo_in        = lo_ff;
      found_in     = found_ff;
      md_in        = md_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;

      // bin returned from the previous scan read
      if (scan_vld_ff && !found_ff) begin
         acc_in = acc_sum;
         if (eq_ff) begin
            if (hist_rd_data != '0) begin
               md_in    = MD_W'(lo_ff) + MD_W'(scan_v_ff);
               found_in = 1'b1;
            end
         end else if (acc_sum >= need) begin
            md_in    = {scan_v_ff, 1'b0};
            found_in = 1'b1;
         end else if (!len_ff[0] && (acc_sum == half)) begin
            eq_in = 1'b1;
            lo_in = scan_v_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               s_in         = s_sat;
               full_in      = (fill_ff >= len_ff);
               scan_addr_in = '0;
               acc_in       = '0;
               eq_in        = 1'b0;
               found_in     = 1'b0;
               md_in        = '0;
               note_in      = 1'b0;
               state_in     = (fill_ff >= len_ff) ? ST_SCAN : ST_INC_RD;
            end
         end
         ST_SCAN: begin
            scan_vld_in = 1'b1;
            scan_v_in   = scan_addr_ff;
            if (scan_addr_ff == VAL_W'(VALUE_MAX)) begin
               state_in = ST_SCAN_END;
            end else begin
               scan_addr_in = scan_addr_ff + VAL_W'(1);
            end
         end
         ST_SCAN_END: begin
            state_in = ST_OLD_RD;
         end
         ST_OLD_RD: begin
            // even window whose upper middle never turned up
            if (!found_ff) begin
               md_in = eq_ff ? {lo_ff, 1'b0} : '0;
            end
            state_in = ST_OLD_WAIT;
         end
         ST_OLD_WAIT: begin
            old_in   = ring_rd_data;
            state_in = ST_DEC;
         end
         ST_DEC: begin
            state_in = ST_INC_RD;
         end
         ST_INC_RD: begin
            state_in = ST_INC_WR;
         end
         ST_INC_WR: begin
            wp_in = (wp_ff == RA_W'(WINDOW_MAX - 1)) ? '0 : wp_ff + RA_W'(1);
            if (!full_ff) begin
               fill_in = fill_ff + CNT_W'(1);
            end else if (MD_W'(s_ff) >= md_ff) begin
               note_in = 1'b1;
               if (alert_ff != '1) begin
                  alert_in = alert_ff + TOTAL_W'(1);
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.window_full    = full_ff;
               rsp_in.median_doubled = MEDIAN_W'(md_ff);
               rsp_in.notify         = note_ff;
               rsp_in.notify_total   = alert_ff;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         len_in  = len_eff;
         fill_in = '0;
         wp_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= CNT_W'(1);
         fill_ff      <= '0;
         wp_ff        <= '0;
         alert_ff     <= '0;
         scan_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         eq_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         wp_ff        <= wp_in;
         alert_ff     <= alert_in;
         scan_vld_ff  <= scan_vld_in;
         found_ff     <= found_in;
         eq_ff        <= eq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff         <= s_in;
      full_ff      <= full_in;
      old_ff       <= old_in;
      note_ff      <= note_in;
      scan_addr_ff <= scan_addr_in;
      scan_v_ff    <= scan_v_in;
      acc_ff       <= acc_in;
      lo_ff        <= lo_in;
      md_ff        <= md_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.window_full    = rsp_ff.window_full;
   assign rsp_ch.median_doubled = rsp_ff.median_doubled;
   assign rsp_ch.notify         = rsp_ff.notify;
   assign rsp_ch.notify_total   = rsp_ff.notify_total;

`ifndef SYNTHESIS
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= len_ff)
      else $error("fill count beyond window length");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ch.ready)
      else $error("second transfer accepted while busy");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_addr_ff <= VAL_W'(VALUE_MAX)))
      else $error("scan address beyond last bin");

   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (alert_ff >= $past(alert_ff)))
      else $error("notification total decreased");

   a_notify_needs_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.notify) |-> rsp_ff.window_full)
      else $error("notify without full window");
`endif

endmodule
`default_nettype wire

// File: hdl/sliding_window_median_alert.sv
// Sequence: a request is taken only while idle. While the window fills it goes through
//   the histogram increment read and write; once full, a median scan comes first, then
//   the oldest sample is read and its bin decremented before the increment. The scan
//   reads one histogram bin per cycle through the single histogram port. The next sample
//   is accepted only after the response is registered, which waits on a stalled output.
// Reset: synchronous, clears histogram valid bits, fill count, ring pointer and total.
`default_nettype none
module sliding_window_median_alert
   import swma_pkg::*;
#(
   parameter int VALUE_MAX  = VALUE_MAX_DEF,
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   swma_req_if.sink              req_ch,
   swma_rsp_if.source            rsp_ch,
   input  wire logic             csr_wr_en,
   input  wire logic [CFG_W-1:0] csr_wr_data
);

   localparam int VAL_W = $clog2(VALUE_MAX + 1);
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int RA_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   // histogram port: scan reads, then decrement of the oldest, then increment
   logic             hist_clear;
   logic             hist_wr_en;
   logic [VAL_W-1:0] hist_addr;
   logic [CNT_W-1:0] hist_wr_data;
   logic [CNT_W-1:0] hist_rd_data;

   // delay line port: read of the oldest sample, write of the new one
   logic             ring_wr_en;
   logic [RA_W-1:0]  ring_addr;
   logic [VAL_W-1:0] ring_wr_data;
   logic [VAL_W-1:0] ring_rd_data;

   swma_ctrl #(
      .VALUE_MAX  (VALUE_MAX),
      .WINDOW_MAX (WINDOW_MAX)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .hist_clear   (hist_clear),
      .hist_wr_en   (hist_wr_en),
      .hist_addr    (hist_addr),
      .hist_wr_data (hist_wr_data),
      .hist_rd_data (hist_rd_data),
      .ring_wr_en   (ring_wr_en),
      .ring_addr    (ring_addr),
      .ring_wr_data (ring_wr_data),
      .ring_rd_data (ring_rd_data)
   );

   // bins cleared at once by the valid bits on reset and window change
   swma_hist_mem #(
      .VALUE_MAX  (VALUE_MAX),
      .WINDOW_MAX (WINDOW_MAX)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .clear   (hist_clear),
      .wr_en   (hist_wr_en),
      .addr    (hist_addr),
      .wr_data (hist_wr_data),
      .rd_data (hist_rd_data)
   );

   // entries only ever read after being written, so no clearing
   swma_ring_mem #(
      .VALUE_MAX  (VALUE_MAX),
      .WINDOW_MAX (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .addr    (ring_addr),
      .wr_data (ring_wr_data),
      .rd_data (ring_rd_data)
   );

endmodule
`default_nettype wire
